FILE: hdl/midi_clock_master_generator_assert.svh
// assertion macros shared by the midi clock master generator rtl
// no dependencies; included by the modules that carry checks
`ifndef MIDI_CLOCK_MASTER_GENERATOR_ASSERT_SVH
`define MIDI_CLOCK_MASTER_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MCMG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MCMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mcmg_pkg.sv
// shared types, constants and codes of the midi clock master generator
// no dependencies; used by every rtl module of the block
`default_nettype none

package mcmg_pkg;

    // parameter defaults
    localparam int TICKS_PER_PULSE_DEF     = 2;
    localparam int TICKS_PER_MIDI_BEAT_DEF = 12;
    localparam int FRAC_BITS_DEF           = 16;
    localparam int MAX_FRAMES_DEF          = 1024;

    // fixed field widths
    localparam int FRAMES_IN_W = 11;
    localparam int TPF_W       = 13;
    localparam int POS_W       = 32;
    localparam int KIND_W      = 3;
    localparam int SPP_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // words per period and the pulse counter that follows from it
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    // constant divider: magnitude of a positive position and the remainder width
    localparam int DIV_W = 31;
    localparam int DVS_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_FRAME = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLOCK    = 3'd0,
        KIND_START    = 3'd1,
        KIND_CONTINUE = 3'd2,
        KIND_STOP     = 3'd3,
        KIND_SONGPOS  = 3'd4
    } kind_t;

    typedef enum logic {
        DIV_BEATS  = 1'b0,
        DIV_PULSES = 1'b1
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_EVAL,
        S_PLAN,
        S_DIV_SPP,
        S_DIV_CLK,
        S_ROUTE,
        S_SEND_SPP,
        S_SEND_CONT,
        S_SEND_START,
        S_SEND_STOP,
        S_SEND_CLK
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     mul;
        logic     eval;
        logic     div_start;
        div_sel_t div_sel;
        logic     spp_clear;
        logic     spp_capture;
        logic     clk_capture;
        logic     out_load;
        kind_t    out_kind;
        logic     out_last;
        logic     pulse_dec;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic enable;
        logic rise;
        logic fall;
        logic seek;
        logic pos_zero;
        logic pos_pos;
        logic running;
        logic div_done;
        logic out_free;
        logic pulses_zero;
        logic pulses_one;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/mcmg_div.sv
// divider by two fixed constants through reciprocal multiplication
// depends on mcmg_pkg and the assertion macro header
`default_nettype none
`include "midi_clock_master_generator_assert.svh"

module mcmg_div #(
    parameter int BEAT_DIV  = mcmg_pkg::TICKS_PER_MIDI_BEAT_DEF,
    parameter int PULSE_DIV = mcmg_pkg::TICKS_PER_PULSE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire mcmg_pkg::div_sel_t          sel,
    input  wire logic [mcmg_pkg::DIV_W-1:0]  num,
    output logic                             done,
    output logic [mcmg_pkg::DIV_W-1:0]       quot,
    output logic [mcmg_pkg::DVS_W-1:0]       rem
);

    localparam int NW       = mcmg_pkg::DIV_W;
    localparam int MW       = NW + 1;
    localparam int PW       = NW + MW;
    localparam int BEAT_SH  = NW + $clog2(BEAT_DIV);
    localparam int PULSE_SH = NW + $clog2(PULSE_DIV);
    // rounded-up reciprocals, exact for every numerator below 2**NW
    localparam longint BEAT_M  = ((longint'(1) << BEAT_SH) + longint'(BEAT_DIV) - 1)
                               / longint'(BEAT_DIV);
    localparam longint PULSE_M = ((longint'(1) << PULSE_SH) + longint'(PULSE_DIV) - 1)
                               / longint'(PULSE_DIV);
    localparam logic [MW-1:0] BEAT_RECIP  = MW'(BEAT_M);
    localparam logic [MW-1:0] PULSE_RECIP = MW'(PULSE_M);
    localparam logic [NW-1:0] BEAT_D      = NW'(BEAT_DIV);
    localparam logic [NW-1:0] PULSE_D     = NW'(PULSE_DIV);

    logic                               a_valid_reg, a_valid_next;
    logic                               done_reg, done_next;
    mcmg_pkg::div_sel_t                 sel_reg, sel_next;
    logic [NW-1:0]                      num_reg, num_next;
    logic [PW-1:0]                      prod_reg, prod_next;
    logic [NW-1:0]                      quot_reg, quot_next;
    logic [mcmg_pkg::DVS_W-1:0]         rem_reg, rem_next;
    logic [MW-1:0]                      recip;
    logic [NW-1:0]                      q_est;
    logic [NW-1:0]                      back;

    // first stage multiplies by the reciprocal, second takes quotient and remainder
    assign recip = (sel == mcmg_pkg::DIV_BEATS) ? BEAT_RECIP : PULSE_RECIP;
    assign q_est = (sel_reg == mcmg_pkg::DIV_BEATS) ? NW'(prod_reg >> BEAT_SH)
                                                     : NW'(prod_reg >> PULSE_SH);
    assign back  = q_est * ((sel_reg == mcmg_pkg::DIV_BEATS) ? BEAT_D : PULSE_D);

    always_comb
    begin
        a_valid_next = start;
        done_next    = a_valid_reg;
        sel_next     = sel_reg;
        num_next     = num_reg;
        prod_next    = prod_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            sel_next  = sel;
            num_next  = num;
            prod_next = PW'(num) * PW'(recip);
        end
        if (a_valid_reg)
        begin
            quot_next = q_est;
            rem_next  = mcmg_pkg::DVS_W'(num_reg - back);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            done_reg    <= done_next;
        end
    end

    // operands and results, no reset
    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        num_reg  <= num_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    // checks
    `MCMG_ASSERT_NEXT(a_div_pipe, clk, rst_n, a_valid_reg, done_reg, "divider result not flagged")

endmodule

`default_nettype wire

FILE: hdl/mcmg_dp.sv
// datapath: config registers, transport state, tick carry, divider and output word
// depends on mcmg_pkg, mcmg_div and the assertion macro header
`default_nettype none
`include "midi_clock_master_generator_assert.svh"

module mcmg_dp #(
    parameter int TICKS_PER_PULSE     = mcmg_pkg::TICKS_PER_PULSE_DEF,
    parameter int TICKS_PER_MIDI_BEAT = mcmg_pkg::TICKS_PER_MIDI_BEAT_DEF,
    parameter int FRAC_BITS           = mcmg_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAMES          = mcmg_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [mcmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcmg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [mcmg_pkg::FRAMES_IN_W-1:0]   period_frames,
    input  wire logic                               transport_running,
    input  wire logic signed [mcmg_pkg::POS_W-1:0]  play_position,
    input  wire mcmg_pkg::dp_cmd_t                  cmd,
    output mcmg_pkg::dp_sts_t                       sts,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mcmg_pkg::KIND_W-1:0]             message_kind,
    output logic [mcmg_pkg::SPP_W-1:0]              song_position,
    output logic signed [mcmg_pkg::POS_W-1:0]       event_position,
    output logic                                    last_of_run
);

    localparam int FRAMES_W = $clog2(MAX_FRAMES + 1);
    localparam int PROD_W   = FRAMES_W + mcmg_pkg::TPF_W;
    localparam int CARRY_W  = $clog2(TICKS_PER_PULSE) + FRAC_BITS;
    localparam int TOT_W    = ((PROD_W > CARRY_W) ? PROD_W : CARRY_W) + 1;
    localparam int CW       = mcmg_pkg::CNT_W;

    // config
    logic                               en_reg, en_next;
    logic [mcmg_pkg::TPF_W-1:0]         tpf_reg, tpf_next;
    // period being worked on
    logic [FRAMES_W-1:0]                frames_reg, frames_next;
    logic                               running_reg, running_next;
    logic signed [mcmg_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [PROD_W-1:0]                  adv_reg, adv_next;
    logic [TOT_W-1:0]                   total_reg, total_next;
    // transport state kept across periods
    logic                               was_running_reg, was_running_next;
    logic                               known_reg, known_next;
    logic signed [mcmg_pkg::POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [CARRY_W-1:0]                 carry_reg, carry_next;
    // decisions of this period
    logic                               rise_reg, rise_next;
    logic                               fall_reg, fall_next;
    logic                               seek_reg, seek_next;
    logic [mcmg_pkg::SPP_W-1:0]         spp_reg, spp_next;
    logic [CW-1:0]                      pulses_reg, pulses_next;
    // output word
    logic                               out_valid_reg, out_valid_next;
    mcmg_pkg::kind_t                    out_kind_reg, out_kind_next;
    logic [mcmg_pkg::SPP_W-1:0]         out_spp_reg, out_spp_next;
    logic signed [mcmg_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic                               out_last_reg, out_last_next;

    logic [FRAMES_W-1:0]                frames_clamped;
    logic signed [mcmg_pkg::POS_W+1:0]  delta;
    logic signed [mcmg_pkg::POS_W+1:0]  expected;
    logic signed [mcmg_pkg::POS_W+1:0]  exp_lo;
    logic signed [mcmg_pkg::POS_W+1:0]  exp_hi;
    logic                               is_edge;
    logic                               seek_now;
    logic [CARRY_W-1:0]                 carry_eff;
    logic                               pos_zero;
    logic [1:0]                         n_trans;
    logic [CW-1:0]                      limit;
    logic [CW-1:0]                      pulses_now;
    logic [mcmg_pkg::DIV_W-1:0]         div_num;
    logic                               div_done;
    logic [mcmg_pkg::DIV_W-1:0]         div_quot;
    logic [mcmg_pkg::DVS_W-1:0]         div_rem;

    // config writes, unknown indexes ignored
    always_comb
    begin
        en_next  = en_reg;
        tpf_next = tpf_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mcmg_pkg::REG_MASTER_ENABLE:   en_next  = cfg_data[0];
                mcmg_pkg::REG_TICKS_PER_FRAME: tpf_next = cfg_data[mcmg_pkg::TPF_W-1:0];
                default:                       ;
            endcase
        end
    end

    // frame count limited to the largest period
    assign frames_clamped = (32'(period_frames) > MAX_FRAMES) ? FRAMES_W'(MAX_FRAMES)
                                                              : FRAMES_W'(period_frames);

    // seek test against the whole-tick advance
    assign delta    = {{2{pos_reg[mcmg_pkg::POS_W-1]}}, pos_reg}
                    - {{2{last_pos_reg[mcmg_pkg::POS_W-1]}}, last_pos_reg};
    assign expected = (mcmg_pkg::POS_W + 2)'(adv_reg >> FRAC_BITS);
    assign exp_lo   = expected - 34'sd1;
    assign exp_hi   = expected + 34'sd1;
    assign is_edge  = running_reg != was_running_reg;
    assign seek_now = running_reg && was_running_reg && known_reg && (delta != 34'sd0)
                      && ((delta < exp_lo) || (delta > exp_hi));
    assign carry_eff = is_edge ? '0 : carry_reg;
    assign pos_zero  = pos_reg == '0;

    // pulses allowed after the transport words
    assign n_trans    = rise_reg ? (pos_zero ? 2'd1 : 2'd2) : (seek_reg ? 2'd1 : 2'd0);
    assign limit      = CW'(mcmg_pkg::MAX_RESULTS) - CW'(n_trans);
    assign pulses_now = (div_quot > mcmg_pkg::DIV_W'(limit)) ? limit : div_quot[CW-1:0];

    // divider operand: beats from position or whole pulses from the tick total
    assign div_num = (cmd.div_sel == mcmg_pkg::DIV_BEATS)
                   ? pos_reg[mcmg_pkg::DIV_W-1:0]
                   : mcmg_pkg::DIV_W'(total_reg[TOT_W-1:FRAC_BITS]);

    mcmg_div #(
        .BEAT_DIV  (TICKS_PER_MIDI_BEAT),
        .PULSE_DIV (TICKS_PER_PULSE)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .sel   (cmd.div_sel),
        .num   (div_num),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // period registers and state updates
    always_comb
    begin
        frames_next      = cmd.load_item ? frames_clamped : frames_reg;
        running_next     = cmd.load_item ? transport_running : running_reg;
        pos_next         = cmd.load_item ? play_position : pos_reg;
        adv_next         = cmd.mul ? PROD_W'(frames_reg) * PROD_W'(tpf_reg) : adv_reg;
        total_next       = cmd.eval ? TOT_W'(carry_eff) + TOT_W'(adv_reg) : total_reg;
        was_running_next = cmd.eval ? running_reg : was_running_reg;
        known_next       = cmd.eval ? 1'b1 : known_reg;
        last_pos_next    = cmd.eval ? pos_reg : last_pos_reg;
        rise_next        = cmd.eval ? (running_reg && !was_running_reg) : rise_reg;
        fall_next        = cmd.eval ? (!running_reg && was_running_reg) : fall_reg;
        seek_next        = cmd.eval ? seek_now : seek_reg;

        carry_next = carry_reg;
        if (cmd.eval && is_edge)
        begin
            carry_next = '0;
        end
        else if (cmd.clk_capture)
        begin
            carry_next = CARRY_W'({div_rem, total_reg[FRAC_BITS-1:0]});
        end

        spp_next = spp_reg;
        if (cmd.spp_clear)
        begin
            spp_next = '0;
        end
        else if (cmd.spp_capture)
        begin
            spp_next = div_quot[mcmg_pkg::SPP_W-1:0];
        end

        pulses_next = pulses_reg;
        if (cmd.eval)
        begin
            pulses_next = '0;
        end
        else if (cmd.clk_capture)
        begin
            pulses_next = pulses_now;
        end
        else if (cmd.pulse_dec)
        begin
            pulses_next = pulses_reg - CW'(1);
        end
    end

    // output word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_spp_next   = out_spp_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.out_kind;
            out_spp_next   = (cmd.out_kind == mcmg_pkg::KIND_SONGPOS) ? spp_reg : '0;
            out_pos_next   = pos_reg;
            out_last_next  = cmd.out_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg          <= 1'b0;
            tpf_reg         <= '0;
            was_running_reg <= 1'b0;
            known_reg       <= 1'b0;
            last_pos_reg    <= '0;
            carry_reg       <= '0;
            rise_reg        <= 1'b0;
            fall_reg        <= 1'b0;
            seek_reg        <= 1'b0;
            pulses_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            en_reg          <= en_next;
            tpf_reg         <= tpf_next;
            was_running_reg <= was_running_next;
            known_reg       <= known_next;
            last_pos_reg    <= last_pos_next;
            carry_reg       <= carry_next;
            rise_reg        <= rise_next;
            fall_reg        <= fall_next;
            seek_reg        <= seek_next;
            pulses_reg      <= pulses_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        frames_reg   <= frames_next;
        running_reg  <= running_next;
        pos_reg      <= pos_next;
        adv_reg      <= adv_next;
        total_reg    <= total_next;
        spp_reg      <= spp_next;
        out_kind_reg <= out_kind_next;
        out_spp_reg  <= out_spp_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    // status to the controller
    always_comb
    begin
        sts.enable      = en_reg;
        sts.rise        = rise_reg;
        sts.fall        = fall_reg;
        sts.seek        = seek_reg;
        sts.pos_zero    = pos_zero;
        sts.pos_pos     = !pos_reg[mcmg_pkg::POS_W-1] && !pos_zero;
        sts.running     = running_reg;
        sts.div_done    = div_done;
        sts.out_free    = !out_valid_reg || out_ready;
        sts.pulses_zero = pulses_reg == '0;
        sts.pulses_one  = pulses_reg == CW'(1);
    end

    assign out_valid      = out_valid_reg;
    assign message_kind   = out_kind_reg;
    assign song_position  = out_spp_reg;
    assign event_position = out_pos_reg;
    assign last_of_run    = out_last_reg;

    // checks
    `MCMG_ASSERT_NOW(a_dp_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "word loaded over one not yet taken")
    `MCMG_ASSERT_NOW(a_dp_dec_nonzero, clk, rst_n, cmd.pulse_dec, pulses_reg != '0, "pulse count underflow")
    `MCMG_ASSERT_NEXT(a_dp_dec_step, clk, rst_n, cmd.pulse_dec, pulses_reg == CW'($past(pulses_reg) - CW'(1)), "pulse count did not step down")

endmodule

`default_nettype wire

FILE: hdl/mcmg_ctrl.sv
// controller: sequences multiply, evaluate, divide and the word send order
// depends on mcmg_pkg and the assertion macro header
`default_nettype none
`include "midi_clock_master_generator_assert.svh"

module mcmg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mcmg_pkg::dp_sts_t  sts,
    output mcmg_pkg::dp_cmd_t       cmd
);

    mcmg_pkg::ctrl_state_t state_reg, state_next;
    logic                  need_spp;

    assign need_spp = (sts.rise && !sts.pos_zero) || sts.seek;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcmg_pkg::S_IDLE:
            begin
                if (in_valid && sts.enable)
                begin
                    state_next = mcmg_pkg::S_MUL;
                end
            end
            mcmg_pkg::S_MUL:  state_next = mcmg_pkg::S_EVAL;
            mcmg_pkg::S_EVAL: state_next = mcmg_pkg::S_PLAN;
            mcmg_pkg::S_PLAN:
            begin
                if (need_spp && sts.pos_pos)
                begin
                    state_next = mcmg_pkg::S_DIV_SPP;
                end
                else if (sts.running)
                begin
                    state_next = mcmg_pkg::S_DIV_CLK;
                end
                else
                begin
                    state_next = mcmg_pkg::S_ROUTE;
                end
            end
            mcmg_pkg::S_DIV_SPP:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.running ? mcmg_pkg::S_DIV_CLK : mcmg_pkg::S_ROUTE;
                end
            end
            mcmg_pkg::S_DIV_CLK:
            begin
                if (sts.div_done)
                begin
                    state_next = mcmg_pkg::S_ROUTE;
                end
            end
            mcmg_pkg::S_ROUTE:
            begin
                if (sts.rise)
                begin
                    state_next = sts.pos_zero ? mcmg_pkg::S_SEND_START : mcmg_pkg::S_SEND_SPP;
                end
                else if (sts.fall)
                begin
                    state_next = mcmg_pkg::S_SEND_STOP;
                end
                else if (sts.seek)
                begin
                    state_next = mcmg_pkg::S_SEND_SPP;
                end
                else
                begin
                    state_next = sts.pulses_zero ? mcmg_pkg::S_IDLE : mcmg_pkg::S_SEND_CLK;
                end
            end
            mcmg_pkg::S_SEND_SPP:
            begin
                if (sts.out_free)
                begin
                    if (sts.rise)
                    begin
                        state_next = mcmg_pkg::S_SEND_CONT;
                    end
                    else
                    begin
                        state_next = sts.pulses_zero ? mcmg_pkg::S_IDLE : mcmg_pkg::S_SEND_CLK;
                    end
                end
            end
            mcmg_pkg::S_SEND_CONT,
            mcmg_pkg::S_SEND_START,
            mcmg_pkg::S_SEND_STOP:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.pulses_zero ? mcmg_pkg::S_IDLE : mcmg_pkg::S_SEND_CLK;
                end
            end
            mcmg_pkg::S_SEND_CLK:
            begin
                if (sts.out_free && sts.pulses_one)
                begin
                    state_next = mcmg_pkg::S_IDLE;
                end
            end
            default: state_next = mcmg_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            mcmg_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid && sts.enable;
            end
            mcmg_pkg::S_MUL:  cmd.mul  = 1'b1;
            mcmg_pkg::S_EVAL: cmd.eval = 1'b1;
            mcmg_pkg::S_PLAN:
            begin
                cmd.spp_clear = 1'b1;
                if (need_spp && sts.pos_pos)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = mcmg_pkg::DIV_BEATS;
                end
                else if (sts.running)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = mcmg_pkg::DIV_PULSES;
                end
            end
            mcmg_pkg::S_DIV_SPP:
            begin
                if (sts.div_done)
                begin
                    cmd.spp_capture = 1'b1;
                    if (sts.running)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = mcmg_pkg::DIV_PULSES;
                    end
                end
            end
            mcmg_pkg::S_DIV_CLK:
            begin
                cmd.div_sel     = mcmg_pkg::DIV_PULSES;
                cmd.clk_capture = sts.div_done;
            end
            mcmg_pkg::S_ROUTE: ;
            mcmg_pkg::S_SEND_SPP:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = mcmg_pkg::KIND_SONGPOS;
                cmd.out_last = !sts.rise && sts.pulses_zero;
            end
            mcmg_pkg::S_SEND_CONT:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = mcmg_pkg::KIND_CONTINUE;
                cmd.out_last = sts.pulses_zero;
            end
            mcmg_pkg::S_SEND_START:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = mcmg_pkg::KIND_START;
                cmd.out_last = sts.pulses_zero;
            end
            mcmg_pkg::S_SEND_STOP:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = mcmg_pkg::KIND_STOP;
                cmd.out_last = sts.pulses_zero;
            end
            mcmg_pkg::S_SEND_CLK:
            begin
                cmd.out_load  = sts.out_free;
                cmd.out_kind  = mcmg_pkg::KIND_CLOCK;
                cmd.out_last  = sts.pulses_one;
                cmd.pulse_dec = sts.out_free;
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcmg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    `MCMG_ASSERT_NEXT(a_ctrl_take, clk, rst_n, (state_reg == mcmg_pkg::S_IDLE) && in_valid && sts.enable, state_reg == mcmg_pkg::S_MUL, "enabled period not taken up")
    `MCMG_ASSERT_NOW(a_ctrl_clk_count, clk, rst_n, state_reg == mcmg_pkg::S_SEND_CLK, !sts.pulses_zero, "sending clock with no pulses left")

endmodule

`default_nettype wire

FILE: hdl/midi_clock_master_generator.sv
// top level of the midi clock master generator (24 ppqn master)
// depends on mcmg_pkg, mcmg_ctrl and mcmg_dp
//
// channel | handshake              | payload
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
// in      | in_valid / in_ready    | period_frames, transport_running, play_position
// out     | out_valid / out_ready  | message_kind, song_position, event_position, last_of_run
//
// an enabled period steps through multiply, evaluate, plan, its divisions, route and one send per word;
// one division for the pulse count while running, one more for a song position
// of a positive play position; both share one two-stage reciprocal multiplier
// words leave one per cycle from a single output register when out_ready is high
// a stalled output holds the sequencer; the next period is taken while the last word waits
// reset clears config, transport state and tick carry; a period with master off is dropped
`default_nettype none

module midi_clock_master_generator #(
    parameter int TICKS_PER_PULSE     = mcmg_pkg::TICKS_PER_PULSE_DEF,
    parameter int TICKS_PER_MIDI_BEAT = mcmg_pkg::TICKS_PER_MIDI_BEAT_DEF,
    parameter int FRAC_BITS           = mcmg_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAMES          = mcmg_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mcmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcmg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [mcmg_pkg::FRAMES_IN_W-1:0]   period_frames,
    input  wire logic                               transport_running,
    input  wire logic signed [mcmg_pkg::POS_W-1:0]  play_position,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mcmg_pkg::KIND_W-1:0]             message_kind,
    output logic [mcmg_pkg::SPP_W-1:0]              song_position,
    output logic signed [mcmg_pkg::POS_W-1:0]       event_position,
    output logic                                    last_of_run
);

    mcmg_pkg::dp_cmd_t cmd;
    mcmg_pkg::dp_sts_t sts;

    // config writes always land
    assign cfg_ready = 1'b1;

    mcmg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcmg_dp #(
        .TICKS_PER_PULSE     (TICKS_PER_PULSE),
        .TICKS_PER_MIDI_BEAT (TICKS_PER_MIDI_BEAT),
        .FRAC_BITS           (FRAC_BITS),
        .MAX_FRAMES          (MAX_FRAMES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .period_frames     (period_frames),
        .transport_running (transport_running),
        .play_position     (play_position),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .message_kind      (message_kind),
        .song_position     (song_position),
        .event_position    (event_position),
        .last_of_run       (last_of_run)
    );

endmodule

`default_nettype wire
